>>> src/dfr_pkg.sv
// Shared types and constants for the datagram fragment reassembler.
package dfr_pkg;

    localparam int BLOB_DEPTH_DEFAULT = 4096;
    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] MAX_OCTETS_RESET = 13'd4096;

    localparam logic [7:0] PART_NUM_MASK = 8'h7f;
    localparam logic [7:0] LAST_PART_BIT = 8'h80;

    typedef enum logic [2:0] {
        PH_SEQ_HI,
        PH_SEQ_LO,
        PH_PART,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_TRAIL
    } phase_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED,
        ST_IGNORED,
        ST_HDR_TRUNC,
        ST_PAY_TRUNC,
        ST_OVERFLOW
    } status_t;

    typedef struct packed {
        logic                is_read;
        logic                in_range;
        status_t             status;
        logic                complete;
        logic [COUNT_W-1:0]  count;
    } result_t;

endpackage

>>> src/dfr_blob_ram.sv
// Blob byte store: one write port and one registered read port.
module dfr_blob_ram #(
    parameter int DEPTH = dfr_pkg::BLOB_DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/datagram_fragment_reassembler.sv
// Datagram fragment reassembler: parses fragment headers, appends payload to a blob store.
//
// The input stream carries one datagram byte or one read command per item.
// s_tuser[0] selects a read, s_tuser[1] marks the first byte of a datagram and
// s_tlast its final byte. Header bytes update the parse state; payload bytes of
// the expected part are written to the blob store at the running count.
// Each final byte yields one status item; each read command yields one reply
// item carrying the stored byte. Other bytes yield no item.
// An item is accepted every cycle while the output side keeps up. A result
// reaches the master side through the synchronous blob read and the result
// stage register, then through the output register.
// The limit on stored bytes is written through cfg_wr_en and cfg_wr_data.
// Reset clears the parse state, the counters and the limit (back to 4096);
// the blob contents are undefined until written.
// When m_tready is low the output register holds its item, the stage behind
// it fills, and s_tready then drops until the output register is taken.
module datagram_fragment_reassembler #(
    parameter int BLOB_DEPTH = dfr_pkg::BLOB_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte, read_address, zero fill
    input  logic [1:0]  s_tuser,   // command, first_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data, status, complete, received_count, zero fill
    output logic [0:0]  m_tuser    // is_read_reply
);

    localparam int AW   = $clog2(BLOB_DEPTH);
    localparam int CW   = $clog2(BLOB_DEPTH + 1);
    localparam int LIMW = (CW > dfr_pkg::COUNT_W) ? CW : dfr_pkg::COUNT_W;

    logic                        s_accept;
    logic                        s1_move;
    logic                        in_command;
    logic                        in_first;
    logic [7:0]                  in_byte;
    logic [11:0]                 in_addr;

    logic [dfr_pkg::COUNT_W-1:0] max_octets_reg;
    dfr_pkg::phase_t             phase_reg, phase_next;
    logic [15:0]                 in_seq_reg, in_seq_next;
    logic [7:0]                  in_part_reg, in_part_next;
    logic [15:0]                 remaining_reg, remaining_next;
    logic [15:0]                 exp_seq_reg, exp_seq_next;
    logic [7:0]                  exp_part_reg, exp_part_next;
    logic                        receiving_reg, receiving_next;
    logic                        skip_reg, skip_next;
    logic                        complete_reg, complete_next;
    logic [dfr_pkg::COUNT_W-1:0] stored_reg, stored_next;
    dfr_pkg::status_t            dg_status_reg, dg_status_next;

    logic                        s1_valid_reg;
    dfr_pkg::result_t            s1_reg, s1_next;
    logic                        emit;
    logic                        out_valid_reg;
    logic [31:0]                 out_data_reg;
    logic                        out_user_reg;

    logic [LIMW-1:0]             limit;
    logic [LIMW-1:0]             max_ext;
    logic [LIMW-1:0]             stored_ext;
    logic [LIMW-1:0]             rd_ext;
    logic                        ram_wr_en;
    logic                        ram_rd_en;
    logic [7:0]                  ram_rd_data;
    logic                        commit;
    dfr_pkg::status_t            st;

    assign in_command = s_tuser[0];
    assign in_first   = s_tuser[1];
    assign in_byte    = s_tdata[7:0];
    assign in_addr    = s_tdata[19:8];

    assign s1_move  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_move;
    assign s_accept = s_tvalid && s_tready;

    assign max_ext    = LIMW'(max_octets_reg);
    assign limit      = (max_ext > LIMW'(BLOB_DEPTH)) ? LIMW'(BLOB_DEPTH) : max_ext;
    assign stored_ext = LIMW'(stored_reg);
    assign rd_ext     = LIMW'(in_addr);
    assign ram_rd_en  = s_accept && in_command;

    always_comb begin
        phase_next     = phase_reg;
        in_seq_next    = in_seq_reg;
        in_part_next   = in_part_reg;
        remaining_next = remaining_reg;
        exp_seq_next   = exp_seq_reg;
        exp_part_next  = exp_part_reg;
        receiving_next = receiving_reg;
        skip_next      = skip_reg;
        complete_next  = complete_reg;
        stored_next    = stored_reg;
        dg_status_next = dg_status_reg;
        ram_wr_en      = 1'b0;
        commit         = 1'b0;
        emit           = 1'b0;
        st             = dfr_pkg::ST_ACCEPTED;
        s1_next        = s1_reg;

        if (s_accept && in_command) begin
            emit             = 1'b1;
            s1_next.is_read  = 1'b1;
            s1_next.in_range = rd_ext < LIMW'(BLOB_DEPTH);
            s1_next.status   = dfr_pkg::ST_ACCEPTED;
            s1_next.complete = complete_reg;
            s1_next.count    = stored_reg;
        end else if (s_accept) begin
            if (in_first) begin
                phase_next     = dfr_pkg::PH_SEQ_HI;
                skip_next      = 1'b0;
                dg_status_next = dfr_pkg::ST_ACCEPTED;
            end
            if (!skip_next) begin
                case (phase_next)
                    dfr_pkg::PH_SEQ_HI: begin
                        in_seq_next = {in_byte, 8'h00};
                        phase_next  = dfr_pkg::PH_SEQ_LO;
                    end
                    dfr_pkg::PH_SEQ_LO: begin
                        in_seq_next = {in_seq_reg[15:8], in_byte};
                        phase_next  = dfr_pkg::PH_PART;
                    end
                    dfr_pkg::PH_PART: begin
                        in_part_next = in_byte;
                        if (in_seq_reg != exp_seq_reg || !receiving_reg) begin
                            if ((in_byte & dfr_pkg::PART_NUM_MASK) != 8'h00) begin
                                skip_next      = 1'b1;
                                dg_status_next = dfr_pkg::ST_IGNORED;
                            end else begin
                                exp_seq_next   = in_seq_reg;
                                exp_part_next  = 8'h00;
                                receiving_next = 1'b1;
                                stored_next    = '0;
                            end
                        end
                        if (!skip_next) begin
                            if ((in_byte & dfr_pkg::PART_NUM_MASK) != exp_part_next) begin
                                skip_next      = 1'b1;
                                dg_status_next = dfr_pkg::ST_IGNORED;
                            end else begin
                                phase_next = dfr_pkg::PH_LEN_HI;
                            end
                        end
                    end
                    dfr_pkg::PH_LEN_HI: begin
                        remaining_next = {in_byte, 8'h00};
                        phase_next     = dfr_pkg::PH_LEN_LO;
                    end
                    dfr_pkg::PH_LEN_LO: begin
                        remaining_next = {remaining_reg[15:8], in_byte};
                        if (remaining_next == 16'd0) begin
                            commit     = 1'b1;
                            phase_next = dfr_pkg::PH_TRAIL;
                        end else begin
                            phase_next = dfr_pkg::PH_PAYLOAD;
                        end
                    end
                    dfr_pkg::PH_PAYLOAD: begin
                        if (stored_ext < limit) begin
                            ram_wr_en   = 1'b1;
                            stored_next = stored_reg + 1'b1;
                        end else begin
                            dg_status_next = dfr_pkg::ST_OVERFLOW;
                        end
                        remaining_next = remaining_reg - 16'd1;
                        if (remaining_next == 16'd0) begin
                            commit     = 1'b1;
                            phase_next = dfr_pkg::PH_TRAIL;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tlast) begin
                st = dg_status_next;
                if (dg_status_next == dfr_pkg::ST_ACCEPTED && !skip_next) begin
                    if (phase_next == dfr_pkg::PH_PAYLOAD) begin
                        st     = dfr_pkg::ST_PAY_TRUNC;
                        commit = 1'b1;
                    end else if (phase_next != dfr_pkg::PH_TRAIL) begin
                        st = dfr_pkg::ST_HDR_TRUNC;
                    end
                end else if (dg_status_next == dfr_pkg::ST_OVERFLOW &&
                             phase_next == dfr_pkg::PH_PAYLOAD) begin
                    commit = 1'b1;
                end
            end
            if (commit) begin
                exp_part_next = exp_part_next + 8'd1;
                if ((in_part_next & dfr_pkg::LAST_PART_BIT) != 8'h00) begin
                    complete_next  = 1'b1;
                    receiving_next = 1'b0;
                    exp_part_next  = 8'h00;
                end
            end
            if (s_tlast) begin
                emit             = 1'b1;
                s1_next.is_read  = 1'b0;
                s1_next.in_range = 1'b0;
                s1_next.status   = st;
                s1_next.complete = complete_next;
                s1_next.count    = stored_next;
                phase_next       = dfr_pkg::PH_SEQ_HI;
                skip_next        = 1'b0;
                dg_status_next   = dfr_pkg::ST_ACCEPTED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_octets_reg <= dfr_pkg::MAX_OCTETS_RESET;
            phase_reg      <= dfr_pkg::PH_SEQ_HI;
            in_seq_reg     <= '0;
            in_part_reg    <= '0;
            remaining_reg  <= '0;
            exp_seq_reg    <= '0;
            exp_part_reg   <= '0;
            receiving_reg  <= 1'b0;
            skip_reg       <= 1'b0;
            complete_reg   <= 1'b0;
            stored_reg     <= '0;
            dg_status_reg  <= dfr_pkg::ST_ACCEPTED;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                max_octets_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            in_seq_reg    <= in_seq_next;
            in_part_reg   <= in_part_next;
            remaining_reg <= remaining_next;
            exp_seq_reg   <= exp_seq_next;
            exp_part_reg  <= exp_part_next;
            receiving_reg <= receiving_next;
            skip_reg      <= skip_next;
            complete_reg  <= complete_next;
            stored_reg    <= stored_next;
            dg_status_reg <= dg_status_next;
            if (s1_move) begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s_tready) begin
                s1_valid_reg <= emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && emit) begin
            s1_reg <= s1_next;
        end
        if (s1_move && s1_valid_reg) begin
            out_user_reg <= s1_reg.is_read;
            out_data_reg <= {7'd0, s1_reg.count, s1_reg.complete, s1_reg.status,
                             (s1_reg.is_read && s1_reg.in_range) ? ram_rd_data : 8'h00};
        end
    end

    dfr_blob_ram #(
        .DEPTH (BLOB_DEPTH),
        .AW    (AW)
    ) u_blob_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (stored_ext[AW-1:0]),
        .wr_data (in_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ext[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && out_valid_reg && !m_tready |-> !s_accept)
        else $error("item accepted while the result stage is blocked");

    a_read_reaches_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && in_command |=> s1_valid_reg && s1_reg.is_read)
        else $error("read command did not produce a pending reply");

    a_write_advances_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |=> stored_reg == $past(stored_reg) + 1'b1)
        else $error("blob write did not advance the stored count");

    a_write_in_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> s_accept && !in_command && stored_ext < limit)
        else $error("blob write outside an accepted payload byte");

endmodule
